/* hw/rtl/wovr_pkg.sv */
// ----------------------------------------------------------------------------
// wovr_pkg
// Shared widths, field offsets, codes and helpers for the visible-rect core.
// ----------------------------------------------------------------------------
package wovr_pkg;

    localparam int COORD_BITS = 24;
    localparam int SIZE_W     = COORD_BITS - 1;
    localparam int AREA_W     = COORD_BITS + 1;

    // s_tdata layout
    localparam int IN_LEFT_LSB    = 0;
    localparam int IN_TOP_LSB     = COORD_BITS;
    localparam int IN_WIDTH_LSB   = 2 * COORD_BITS;
    localparam int IN_HEIGHT_LSB  = 2 * COORD_BITS + SIZE_W;
    localparam int IN_MODE_LSB    = 2 * COORD_BITS + 2 * SIZE_W;
    localparam int IN_PANEL_BIT   = IN_MODE_LSB + 2;
    localparam int IN_SELF_BIT    = IN_PANEL_BIT + 1;
    localparam int IN_HIDDEN_BIT  = IN_PANEL_BIT + 2;
    localparam int IN_FOCUS_BIT   = IN_PANEL_BIT + 3;
    localparam int IN_TRANSP_BIT  = IN_PANEL_BIT + 4;
    localparam int IN_FIELDS_W    = IN_TRANSP_BIT + 1;
    localparam int IN_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

    // m_tdata layout
    localparam int OUT_FIELDS_W   = 2 * AREA_W + 2 * SIZE_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = COORD_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_EN    = 3'd4;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_WINDOW = 1'b1;

    localparam logic [1:0] MODE_NORMAL       = 2'd0;
    localparam logic [1:0] MODE_TARGET_FULL  = 2'd1;
    localparam logic [1:0] MODE_OTHER_FULL   = 2'd2;
    localparam logic [1:0] MODE_TARGET_FOCUS = 2'd3;

    typedef logic signed [AREA_W-1:0] coord_t;

    typedef struct packed {
        logic       cmd;
        coord_t     left;
        coord_t     top;
        coord_t     right;
        coord_t     bottom;
        logic [1:0] mode;
        logic       panel;
        logic       self_win;
        logic       hidden;
        logic       focus;
        logic       transp;
        logic       last;
    } item_t;

    function automatic coord_t ext_pos(logic [COORD_BITS-1:0] v);
        return coord_t'({v[COORD_BITS-1], v});
    endfunction

    function automatic coord_t ext_size(logic [SIZE_W-1:0] v);
        return coord_t'({{(AREA_W - SIZE_W){1'b0}}, v});
    endfunction

endpackage

/* hw/rtl/window_occlusion_visible_rect_core.sv */
// ----------------------------------------------------------------------------
// window_occlusion_visible_rect_core
// Clips a target window to the view and trims it by the windows stacked over it.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake         Contents
// s_*       in   tvalid/tready     query or group window transaction
// m_*       out  tvalid/tready     visible rectangle, one per last window
// cfg_wr_*  in   write enable      view rectangle and blend enable
//
// One transaction per cycle unless m_ stalls; m_tvalid comes from a register.
// The running area update is a combinational loop on the area registers.
// Reset is synchronous; control state and config registers clear, area reads
// as empty. A stalled m_ holds the input register; s_tready follows.
// ----------------------------------------------------------------------------
module window_occlusion_visible_rect_core
    import wovr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // rect_left, rect_top, rect_width, rect_height, target_mode,
    // target_is_panel, is_self, is_hidden, has_focus, is_transparent, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]             s_tuser,   // command
    input  logic                   s_tlast,   // last_window

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_left, out_top, out_width, out_height
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]             m_tuser    // is_empty
);

    logic [COORD_BITS-1:0] view_left_reg, view_top_reg;
    logic [SIZE_W-1:0]     view_width_reg, view_height_reg;
    logic                  blend_en_reg;

    logic   in_valid_reg, in_valid_next;
    item_t  item_reg;

    coord_t area_left_reg, area_top_reg, area_right_reg, area_bottom_reg;
    coord_t area_left_next, area_top_next, area_right_next, area_bottom_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_y_reg, origin_x_next, origin_y_next;
    logic [1:0] mode_reg, mode_next;
    logic       panel_reg, panel_next;
    logic       above_reg, above_next;
    logic       gone_reg, gone_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_empty_reg, out_empty_next;

    logic   advance, s_accept, emit;
    coord_t view_l, view_t, view_r, view_b;
    coord_t q_l, q_t, q_r, q_b;
    coord_t il, ir, it, ib;
    coord_t nl, nt, nr, nb;
    logic   hspan, vspan, zero_size, overlap, occl, opaque;
    logic [AREA_W-1:0] rel_x, rel_y;
    logic [AREA_W-1:0] span_x, span_y;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign emit     = advance && (item_reg.cmd == CMD_WINDOW) && item_reg.last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_empty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_left_reg   <= '0;
            view_top_reg    <= '0;
            view_width_reg  <= '0;
            view_height_reg <= '0;
            blend_en_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_VIEW_LEFT:   view_left_reg   <= cfg_wr_data;
                REG_VIEW_TOP:    view_top_reg    <= cfg_wr_data;
                REG_VIEW_WIDTH:  view_width_reg  <= cfg_wr_data[SIZE_W-1:0];
                REG_VIEW_HEIGHT: view_height_reg <= cfg_wr_data[SIZE_W-1:0];
                REG_BLEND_EN:    blend_en_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Input register: decode and form right/bottom edges on capture
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.cmd      <= s_tuser[0];
            item_reg.left     <= ext_pos(s_tdata[IN_LEFT_LSB +: COORD_BITS]);
            item_reg.top      <= ext_pos(s_tdata[IN_TOP_LSB +: COORD_BITS]);
            item_reg.right    <= ext_pos(s_tdata[IN_LEFT_LSB +: COORD_BITS])
                               + ext_size(s_tdata[IN_WIDTH_LSB +: SIZE_W]);
            item_reg.bottom   <= ext_pos(s_tdata[IN_TOP_LSB +: COORD_BITS])
                               + ext_size(s_tdata[IN_HEIGHT_LSB +: SIZE_W]);
            item_reg.mode     <= s_tdata[IN_MODE_LSB +: 2];
            item_reg.panel    <= s_tdata[IN_PANEL_BIT];
            item_reg.self_win <= s_tdata[IN_SELF_BIT];
            item_reg.hidden   <= s_tdata[IN_HIDDEN_BIT];
            item_reg.focus    <= s_tdata[IN_FOCUS_BIT];
            item_reg.transp   <= s_tdata[IN_TRANSP_BIT];
            item_reg.last     <= s_tlast;
        end
    end

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_comb begin
        view_l = ext_pos(view_left_reg);
        view_t = ext_pos(view_top_reg);
        view_r = view_l + ext_size(view_width_reg);
        view_b = view_t + ext_size(view_height_reg);

        q_l = (item_reg.left   > view_l) ? item_reg.left   : view_l;
        q_t = (item_reg.top    > view_t) ? item_reg.top    : view_t;
        q_r = (item_reg.right  < view_r) ? item_reg.right  : view_r;
        q_b = (item_reg.bottom < view_b) ? item_reg.bottom : view_b;

        // occluder against running area
        hspan     = (item_reg.left <= area_left_reg) && (item_reg.right >= area_right_reg);
        vspan     = (item_reg.top <= area_top_reg) && (item_reg.bottom >= area_bottom_reg);
        zero_size = (item_reg.right <= item_reg.left) || (item_reg.bottom <= item_reg.top);
        il = (item_reg.left   > area_left_reg)   ? item_reg.left   : area_left_reg;
        ir = (item_reg.right  < area_right_reg)  ? item_reg.right  : area_right_reg;
        it = (item_reg.top    > area_top_reg)    ? item_reg.top    : area_top_reg;
        ib = (item_reg.bottom < area_bottom_reg) ? item_reg.bottom : area_bottom_reg;
        overlap = (ir > il) && (ib > it);
        occl    = above_reg || item_reg.focus;
        opaque  = !blend_en_reg || !item_reg.transp;

        nl = area_left_reg;
        nt = area_top_reg;
        nr = area_right_reg;
        nb = area_bottom_reg;
        if (hspan) begin
            if (item_reg.top <= area_top_reg) begin
                nt = ib;
            end else if (item_reg.bottom >= area_bottom_reg) begin
                nb = it;
            end
        end else if (vspan) begin
            if (item_reg.left <= area_left_reg) begin
                nl = ir;
            end else if (item_reg.right >= area_right_reg) begin
                nr = il;
            end
        end

        area_left_next   = area_left_reg;
        area_top_next    = area_top_reg;
        area_right_next  = area_right_reg;
        area_bottom_next = area_bottom_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        mode_next        = mode_reg;
        panel_next       = panel_reg;
        above_next       = above_reg;
        gone_next        = gone_reg;

        if (advance) begin
            if (item_reg.cmd == CMD_QUERY) begin
                origin_x_next    = item_reg.left[COORD_BITS-1:0];
                origin_y_next    = item_reg.top[COORD_BITS-1:0];
                mode_next        = item_reg.mode;
                panel_next       = item_reg.panel;
                above_next       = 1'b0;
                area_left_next   = q_l;
                area_top_next    = q_t;
                area_right_next  = q_r;
                area_bottom_next = q_b;
                gone_next        = (q_r <= q_l) || (q_b <= q_t)
                                   || (item_reg.mode == MODE_OTHER_FULL);
            end else if (!gone_reg && (mode_reg == MODE_NORMAL)) begin
                if (item_reg.self_win) begin
                    above_next = !panel_reg;
                end else if (!item_reg.hidden && occl && opaque && !zero_size) begin
                    if (hspan && vspan) begin
                        gone_next = 1'b1;
                    end else if (overlap) begin
                        area_left_next   = nl;
                        area_top_next    = nt;
                        area_right_next  = nr;
                        area_bottom_next = nb;
                        gone_next        = (nr <= nl) || (nb <= nt);
                    end
                end
            end
        end

        rel_x  = area_left_next - ext_pos(origin_x_next);
        rel_y  = area_top_next - ext_pos(origin_y_next);
        span_x = area_right_next - area_left_next;
        span_y = area_bottom_next - area_top_next;

        out_data_next  = out_data_reg;
        out_empty_next = out_empty_reg;
        if (emit) begin
            out_empty_next = gone_next;
            if (gone_next) begin
                out_data_next = '0;
            end else begin
                out_data_next = OUT_TDATA_W'({span_y[SIZE_W-1:0], span_x[SIZE_W-1:0],
                                              rel_y, rel_x});
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            area_left_reg   <= '0;
            area_top_reg    <= '0;
            area_right_reg  <= '0;
            area_bottom_reg <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            mode_reg        <= MODE_NORMAL;
            panel_reg       <= 1'b0;
            above_reg       <= 1'b0;
            gone_reg        <= 1'b1;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            area_left_reg   <= area_left_next;
            area_top_reg    <= area_top_next;
            area_right_reg  <= area_right_next;
            area_bottom_reg <= area_bottom_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            mode_reg        <= mode_next;
            panel_reg       <= panel_next;
            above_reg       <= above_next;
            gone_reg        <= gone_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_empty_reg <= out_empty_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_area_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        !gone_reg |-> (area_right_reg > area_left_reg) && (area_bottom_reg > area_top_reg))
        else $error("live area has no extent");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(emit))
        else $error("result without a last window transaction");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0))
        else $error("empty result carries data");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("input register lost a pending transaction");

endmodule
